// ===== sv/fss_pkg.sv =====
// Shared types and constants of the fuzzy subsequence scorer.
package fss_pkg;

  localparam int unsigned PatBytes = 32;
  localparam int unsigned PatWords = 4;
  localparam int unsigned LenW     = 6;
  localparam int unsigned WordW    = 64;
  localparam int unsigned ScoreW   = 10;
  localparam int unsigned SumW     = 9;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD0  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD1  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD2  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD3  = 3'd4;

  localparam logic [3:0] BONUS_RUN    = 4'd6;
  localparam logic [3:0] BONUS_SINGLE = 4'd1;
  localparam logic [3:0] BONUS_WORD   = 4'd4;
  localparam logic [SumW-1:0] SUM_LIMIT = 9'd511;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic       last_char;
    logic       char_present;
    logic [7:0] hay_char;
  } fss_item_t;

  typedef struct packed {
    logic                     matched;
    logic signed [ScoreW-1:0] score;
  } fss_result_t;

  typedef struct packed {
    logic [LenW-1:0]          length;
    logic [PatBytes-1:0][7:0] bytes;
  } fss_pattern_t;

endpackage

// ===== sv/fuzzy_subsequence_scorer.sv =====
// Top level of the fuzzy subsequence scorer: input register, scoring step, result register.
//
//   Channel   Direction  tdata (low bit up)   tuser          tlast
//   s_axis    in         hay_char [7:0]       char_present   last_char
//   m_axis    out        score [9:0], zeros   matched        -
//   cfg       in         write enable, register index, 64-bit write data
//
// One byte is accepted every cycle while the input does not stall; the scoring step between the input register
// and the state registers sets that rate.
// A result is registered in the output register when the word carrying last_char leaves the input register.
// The input stalls only while a result waits in the output register and the
// next word in the input register is also a last word.
// Reset clears the pattern to empty and the haystack state to its start.
module fuzzy_subsequence_scorer
  import fss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN  = 32,
  parameter int unsigned MAX_HAYSTACK = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // hay_char [7:0]
  input  logic               s_axis_tuser,  // char_present
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // score [9:0], zeros [15:10]
  output logic               m_axis_tuser,  // matched
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  fss_pattern_t pattern;
  fss_result_t  result;

  logic        in_valid_q, in_valid_d;
  fss_item_t   in_item_q;
  logic        out_valid_q, out_valid_d;
  fss_result_t out_q;
  logic        s_accept;
  logic        advance;

  fss_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pattern_o (pattern)
  );

  fss_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_HAYSTACK(MAX_HAYSTACK)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .pattern_i(pattern),
    .result_o (result)
  );

  always_comb begin
    advance = in_valid_q && (!in_item_q.last_char || !out_valid_q || m_axis_tready);
    s_axis_tready = !in_valid_q || advance;
    s_accept = s_axis_tvalid && s_axis_tready;

    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && in_item_q.last_char) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.hay_char     <= s_axis_tdata;
      in_item_q.char_present <= s_axis_tuser;
      in_item_q.last_char    <= s_axis_tlast;
    end
    if (advance && in_item_q.last_char) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - ScoreW){1'b0}}, out_q.score};
  assign m_axis_tuser  = out_q.matched;

endmodule

// ===== sv/fss_cfg.sv =====
// Configuration registers holding the pattern length and pattern bytes.
module fss_cfg
  import fss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  output fss_pattern_t       pattern_o
);

  logic [LenW-1:0]                len_q, len_d;
  logic [PatWords-1:0][WordW-1:0] words_q, words_d;

  always_comb begin
    len_d   = len_q;
    words_d = words_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_LENGTH: len_d      = cfg_data_i[LenW-1:0];
        REG_PATTERN_WORD0:  words_d[0] = cfg_data_i;
        REG_PATTERN_WORD1:  words_d[1] = cfg_data_i;
        REG_PATTERN_WORD2:  words_d[2] = cfg_data_i;
        REG_PATTERN_WORD3:  words_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      words_q <= '0;
    end else begin
      len_q   <= len_d;
      words_q <= words_d;
    end
  end

  assign pattern_o.length = len_q;
  assign pattern_o.bytes  = words_q;

endmodule

// ===== sv/fss_core.sv =====
// Per-haystack match state and the combinational scoring step.
module fss_core
  import fss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN  = 32,
  parameter int unsigned MAX_HAYSTACK = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  fss_item_t    item_i,
  input  fss_pattern_t pattern_i,
  output fss_result_t  result_o
);

  localparam int unsigned CntW = $clog2(MAX_HAYSTACK);
  localparam int unsigned DiffW = ((CntW > SumW) ? CntW : SumW) + 1;
  localparam logic [CntW-1:0] CountMax = CntW'(MAX_HAYSTACK - 1);
  localparam logic [LenW:0] MaxPat = (LenW + 1)'(MAX_PATTERN);

  logic [LenW-1:0] pos_q, pos_d, pos_n;
  logic            prev_q, prev_d, prev_n;
  logic            ws_q, ws_d, ws_n;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_n;
  logic [SumW-1:0] sum_q, sum_d, sum_n;

  logic [LenW-1:0]  len_eff;
  logic [7:0]       pat_byte;
  logic             hit;
  logic [3:0]       add;
  logic [SumW:0]    sum_wide;
  logic [DiffW-1:0] diff;

  always_comb begin
    len_eff = ({1'b0, pattern_i.length} > MaxPat) ? MaxPat[LenW-1:0] : pattern_i.length;
    pat_byte = (pos_q < LenW'(PatBytes)) ? pattern_i.bytes[pos_q[4:0]] : 8'h00;
    hit = item_i.char_present && (pos_q < len_eff) && (item_i.hay_char == pat_byte);
    add = (prev_q ? BONUS_RUN : BONUS_SINGLE) + (ws_q ? BONUS_WORD : 4'd0);
    sum_wide = {1'b0, sum_q} + {{(SumW + 1 - 4){1'b0}}, add};

    pos_n  = pos_q;
    prev_n = prev_q;
    ws_n   = ws_q;
    cnt_n  = cnt_q;
    sum_n  = sum_q;
    if (item_i.char_present) begin
      prev_n = hit;
      ws_n   = (item_i.hay_char == CHAR_SPACE) || (item_i.hay_char == CHAR_SLASH);
      if (cnt_q != CountMax) begin
        cnt_n = cnt_q + 1'b1;
      end
      if (hit) begin
        pos_n = pos_q + 1'b1;
        sum_n = sum_wide[SumW] ? SUM_LIMIT : sum_wide[SumW-1:0];
      end
    end

    diff = DiffW'(sum_n) - DiffW'(cnt_n >> 3);
    if (len_eff == '0) begin
      result_o.matched = 1'b1;
      result_o.score   = '0;
    end else if (pos_n >= len_eff) begin
      result_o.matched = 1'b1;
      result_o.score   = diff[ScoreW-1:0];
    end else begin
      result_o.matched = 1'b0;
      result_o.score   = '0;
    end

    pos_d  = pos_q;
    prev_d = prev_q;
    ws_d   = ws_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    if (step_i) begin
      if (item_i.last_char) begin
        pos_d  = '0;
        prev_d = 1'b0;
        ws_d   = 1'b1;
        cnt_d  = '0;
        sum_d  = '0;
      end else begin
        pos_d  = pos_n;
        prev_d = prev_n;
        ws_d   = ws_n;
        cnt_d  = cnt_n;
        sum_d  = sum_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= 1'b0;
      ws_q   <= 1'b1;
      cnt_q  <= '0;
      sum_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      prev_q <= prev_d;
      ws_q   <= ws_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ===== sv/fss_checker.sv =====
// Port-level checks of the fuzzy subsequence scorer, bound to its top level.
module fss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_reset_no_result : assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("Result word shown during reset.");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled result word changed.");

  a_no_match_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("Unmatched result carries a nonzero score.");

  a_input_flows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("Input stalled although the output side is ready.");

  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'b000000)
    else $error("Padding bits of the result word are not zero.");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (.*);
